FILE: rtl/masgcd_pkg.sv
// Shared constants for the shift-subtract greatest common divisor block.
`timescale 1ns / 1ps
package masgcd_pkg;

  localparam int FIELD_BITS   = 24;
  localparam int DIVISOR_BITS = 24;
  localparam int COUNT_BITS   = 6;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 6'd63;
  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 32;

endpackage

FILE: rtl/masgcd_align.sv
// Alignment unit: shifts the smaller value so its top set bit meets the larger's top set bit.
`timescale 1ns / 1ps
module masgcd_align #(
  parameter int W = 24
) (
  input  logic [W-1:0] big,
  input  logic [W-1:0] small_val,
  output logic [W-1:0] aligned
);

  localparam int LW = $clog2(W + 1);

  logic [LW-1:0] len_big;
  logic [LW-1:0] len_small;
  logic [LW-1:0] shift;

  always_comb begin
    len_big   = '0;
    len_small = '0;
    for (int i = 0; i < W; i++) begin
      if (big[i]) begin
        len_big = LW'(i + 1);
      end
      if (small_val[i]) begin
        len_small = LW'(i + 1);
      end
    end
  end

  assign shift   = len_big - len_small;
  assign aligned = small_val << shift;

endmodule

FILE: rtl/masgcd_sub.sv
// Subtract and reorder unit: replaces the larger value by the absolute difference and reorders.
`timescale 1ns / 1ps
module masgcd_sub #(
  parameter int W = 24
) (
  input  logic [W-1:0] big,
  input  logic [W-1:0] small_val,
  input  logic [W-1:0] aligned,
  output logic [W-1:0] big_next,
  output logic [W-1:0] small_next
);

  logic [W-1:0] diff;

  assign diff = (big >= aligned) ? (big - aligned) : (aligned - big);

  always_comb begin
    if (diff < small_val) begin
      big_next   = small_val;
      small_next = diff;
    end else begin
      big_next   = diff;
      small_next = small_val;
    end
  end

endmodule

FILE: rtl/msb_aligned_subtractive_gcd.sv
// Top level of the shift-subtract greatest common divisor block with its sequencer.
// An accepted request is reduced in S steps, where S is the number of reduction steps
// (at most 48 at the default width), and its result is then loaded in the finish state.
// A new request is accepted only in idle, after the last result is loaded; each step runs an
// align state and then a subtract state in the shared units. A result still waiting in
// the output register holds the sequencer in its finish state until the result is taken.
// Reset: synchronous rst returns the sequencer to idle and empties the result register.
`timescale 1ns / 1ps
module msb_aligned_subtractive_gcd #(
  parameter int OPERAND_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: first_operand[23:0], second_operand[47:24].
  input  logic [masgcd_pkg::IN_DATA_BITS-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: divisor[23:0], step_count[29:24], zero padding[31:30].
  output logic [masgcd_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

  localparam int W    = OPERAND_BITS;
  localparam int WIDE = (OPERAND_BITS > masgcd_pkg::FIELD_BITS) ?
                        OPERAND_BITS : masgcd_pkg::FIELD_BITS;

  typedef enum logic [1:0] {
    IDLE,
    ALIGN,
    SUB,
    FINISH
  } state_t;

  state_t state;
  logic [W-1:0] big;
  logic [W-1:0] small_val;
  logic [W-1:0] aligned;
  logic [masgcd_pkg::COUNT_BITS-1:0] count;
  logic [masgcd_pkg::DIVISOR_BITS-1:0] out_divisor;
  logic [masgcd_pkg::COUNT_BITS-1:0] out_count;

  logic [WIDE-1:0] first_wide;
  logic [WIDE-1:0] second_wide;
  logic [WIDE-1:0] big_wide;
  logic [W-1:0] first_op;
  logic [W-1:0] second_op;
  logic [W-1:0] aligned_next;
  logic [W-1:0] big_next;
  logic [W-1:0] small_next;
  logic in_accept;

  assign first_wide  = WIDE'(s_axis_tdata[masgcd_pkg::FIELD_BITS-1:0]);
  assign second_wide = WIDE'(s_axis_tdata[2*masgcd_pkg::FIELD_BITS-1:masgcd_pkg::FIELD_BITS]);
  assign first_op    = first_wide[W-1:0];
  assign second_op   = second_wide[W-1:0];
  assign big_wide    = WIDE'(big);

  assign s_axis_tready = (state == IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {2'b00, out_count, out_divisor};

  masgcd_align #(.W(W)) u_align (
    .big       (big),
    .small_val (small_val),
    .aligned   (aligned_next)
  );

  masgcd_sub #(.W(W)) u_sub (
    .big        (big),
    .small_val  (small_val),
    .aligned    (aligned),
    .big_next   (big_next),
    .small_next (small_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_accept) begin
            count <= '0;
            if (first_op >= second_op) begin
              big       <= first_op;
              small_val <= second_op;
              state     <= (second_op == '0) ? FINISH : ALIGN;
            end else begin
              big       <= second_op;
              small_val <= first_op;
              state     <= (first_op == '0) ? FINISH : ALIGN;
            end
          end
        end
        ALIGN: begin
          aligned <= aligned_next;
          state   <= SUB;
        end
        SUB: begin
          big       <= big_next;
          small_val <= small_next;
          if (count != masgcd_pkg::COUNT_MAX) begin
            count <= count + 1'b1;
          end
          state <= (small_next == '0) ? FINISH : ALIGN;
        end
        FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_divisor   <= big_wide[masgcd_pkg::DIVISOR_BITS-1:0];
            out_count     <= count;
            m_axis_tvalid <= 1'b1;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_sub_order: assert property (@(posedge clk) disable iff (rst)
    (state == SUB) |-> (aligned >= small_val) && (big >= small_val) && (small_val != '0))
    else $error("Aligned value out of order with the operand pair.");

  a_align_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ALIGN) |-> (small_val != '0) && (big >= small_val))
    else $error("Reduction step started with a zero or misordered pair.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_axis_tready)
    else $error("Sequencer stayed idle after accepting a request.");

  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    (state == FINISH) && !m_axis_tvalid |=> m_axis_tvalid && (state == IDLE))
    else $error("Result was not loaded on completion.");

endmodule
